// ===== hw/rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int MODE_W   = 2;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 16;
  localparam int INDEX_W  = 3;
  localparam int MASK_W   = 8;

  localparam int MS_SUB_W  = 10;
  localparam int SEC_SUB_W = 6;
  localparam logic [MS_SUB_W-1:0]  MS_LAST  = MS_SUB_W'(999);
  localparam logic [SEC_SUB_W-1:0] SEC_LAST = SEC_SUB_W'(59);

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [MODE_W-1:0] {
    OP_TICK    = 2'd0,
    OP_CREATE  = 2'd1,
    OP_COLLECT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic                tick;
    logic                create;
    logic                collect;
    logic [PERIOD_W-1:0] period;
  } step_t;

  typedef struct packed {
    logic [INDEX_W-1:0] slot_index;
    logic               create_failed;
    logic [MASK_W-1:0]  run_mask;
  } slot_res_t;

  typedef struct packed {
    logic [COUNT_W-1:0] ms;
    logic [COUNT_W-1:0] sec;
    logic [COUNT_W-1:0] min;
  } time_t;

endpackage

// ===== hw/rtl/pts_clock.sv =====
// ----------------------------------------------------------------------------
// pts_clock
// Millisecond, second and minute counters with their roll-over sub-counters.
// ----------------------------------------------------------------------------
module pts_clock (
  input  logic            clk,
  input  logic            rst,
  input  logic            tick,
  output pts_pkg::time_t  time_next
);

  pts_pkg::time_t                   now;
  logic [pts_pkg::MS_SUB_W-1:0]     ms_in_second, ms_in_second_next;
  logic [pts_pkg::SEC_SUB_W-1:0]    sec_in_minute, sec_in_minute_next;

  always_comb begin
    time_next          = now;
    ms_in_second_next  = ms_in_second;
    sec_in_minute_next = sec_in_minute;
    if (tick) begin
      time_next.ms = now.ms + 1'b1;
      if (ms_in_second == pts_pkg::MS_LAST) begin
        ms_in_second_next = '0;
        time_next.sec     = now.sec + 1'b1;
        if (sec_in_minute == pts_pkg::SEC_LAST) begin
          sec_in_minute_next = '0;
          time_next.min      = now.min + 1'b1;
        end else begin
          sec_in_minute_next = sec_in_minute + 1'b1;
        end
      end else begin
        ms_in_second_next = ms_in_second + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now           <= '0;
      ms_in_second  <= '0;
      sec_in_minute <= '0;
    end else begin
      now           <= time_next;
      ms_in_second  <= ms_in_second_next;
      sec_in_minute <= sec_in_minute_next;
    end
  end

endmodule

// ===== hw/rtl/pts_slots.sv =====
// ----------------------------------------------------------------------------
// pts_slots
// Slot bank: parallel countdown on a tick, first-free allocation on a
// create, run flag report and clear on a collect.
// ----------------------------------------------------------------------------
module pts_slots (
  input  logic                clk,
  input  logic                rst,
  input  pts_pkg::step_t      step,
  output pts_pkg::slot_res_t  res
);

  localparam int N = pts_pkg::NUM_SLOTS;

  logic [N-1:0]                  used;
  logic [N-1:0]                  run;
  logic [pts_pkg::PERIOD_W-1:0]  countdown [N];
  logic [pts_pkg::PERIOD_W-1:0]  period    [N];

  logic                          any_free;
  logic [pts_pkg::SLOT_IDX_W-1:0] free_idx;
  logic [31:0]                   free_idx_wide;
  logic [pts_pkg::MASK_W-1:0]    mask_view;

  // lowest free slot wins: scan downward so the last hit is the lowest
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used[i]) begin
        any_free = 1'b1;
        free_idx = pts_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  assign free_idx_wide = 32'(free_idx);

  for (genvar b = 0; b < pts_pkg::MASK_W; b++) begin : g_mask
    if (b < N) begin : g_on
      assign mask_view[b] = run[b];
    end else begin : g_off
      assign mask_view[b] = 1'b0;
    end
  end

  always_comb begin
    res = '0;
    if (step.create) begin
      res.create_failed = !any_free;
      res.slot_index    = any_free ? free_idx_wide[pts_pkg::INDEX_W-1:0] : '0;
    end
    if (step.collect) begin
      res.run_mask = mask_view;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      run  <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (step.tick && used[i]) begin
          if (countdown[i] <= pts_pkg::PERIOD_W'(1)) begin
            run[i] <= 1'b1;
          end
        end
        if (step.create && any_free && free_idx == pts_pkg::SLOT_IDX_W'(i)) begin
          used[i] <= 1'b1;
          run[i]  <= 1'b0;
        end
        if (step.collect) begin
          run[i] <= 1'b0;
        end
      end
    end
  end

  // countdown and period only matter once a slot is used; create sets both
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (step.tick && used[i]) begin
        if (countdown[i] <= pts_pkg::PERIOD_W'(1)) begin
          countdown[i] <= period[i];
        end else begin
          countdown[i] <= countdown[i] - 1'b1;
        end
      end
      if (step.create && any_free && free_idx == pts_pkg::SLOT_IDX_W'(i)) begin
        countdown[i] <= '0;
        period[i]    <= step.period;
      end
    end
  end

endmodule

// ===== hw/rtl/periodic_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Tick counters and periodic slot scheduler behind an input and a result
// register.
// ----------------------------------------------------------------------------
// Each input beat is one operation chosen by s_tuser: a millisecond tick,
// a create of a periodic slot, or a collect of the run flags. Every beat
// gives exactly one result beat, in order. A beat is taken into an input
// register, processed as it moves into the result register, and the
// block takes one beat per cycle as long as m_tready keeps up. All slots
// count down in parallel on a tick and a create picks the lowest free
// slot through a priority encoder, so neither bounds the rate. Slots are
// never freed.
module periodic_task_tick_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // period[15:0]
  input  logic [pts_pkg::IN_DATA_W-1:0]     s_tdata,
  // mode[1:0], zero above
  input  logic [pts_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // slot_index[2:0], create_failed[3], run_mask[11:4],
  // millisecond_count[27:12], second_count[43:28], minute_count[59:44]
  output logic [pts_pkg::OUT_DATA_W-1:0]    m_tdata
);

  logic                              in_valid;
  logic [pts_pkg::MODE_W-1:0]        in_mode;
  logic [pts_pkg::PERIOD_W-1:0]      in_period;
  logic                              advance;

  logic                              out_valid;
  logic [pts_pkg::OUT_DATA_W-1:0]    out_data;

  pts_pkg::step_t                    step;
  pts_pkg::slot_res_t                slot_res;
  pts_pkg::time_t                    time_next;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode   <= s_tuser[pts_pkg::MODE_W-1:0];
      in_period <= s_tdata[pts_pkg::PERIOD_W-1:0];
    end
  end

  always_comb begin
    step        = '0;
    step.period = in_period;
    if (advance) begin
      case (pts_pkg::op_t'(in_mode))
        pts_pkg::OP_TICK:    step.tick    = 1'b1;
        pts_pkg::OP_CREATE:  step.create  = 1'b1;
        pts_pkg::OP_COLLECT: step.collect = 1'b1;
        default:             ;
      endcase
    end
  end

  pts_clock u_clock (
    .clk       (clk),
    .rst       (rst),
    .tick      (step.tick),
    .time_next (time_next)
  );

  pts_slots u_slots (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .res  (slot_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {4'b0000, time_next.min, time_next.sec, time_next.ms,
                   slot_res.run_mask, slot_res.create_failed, slot_res.slot_index};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
